// File: src/rmon_pkg.sv
// rmon_pkg: shared types and constants of the I/O rate monitor.
// Used by rmon_front, rmon_queue, rmon_back and io_rate_monitor.
package rmon_pkg;

  localparam int unsigned RING_SLOTS_DEF  = 3;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  // Holds any slot advance up to and including the largest ring (31 slots).
  localparam int unsigned STEP_W          = 5;
  localparam int unsigned GAP_W           = 8;
  localparam logic [GAP_W-1:0] REPORT_GAP_RESET = 8'd2;
  localparam int unsigned BYTES_W         = 31;
  localparam int unsigned IN_DATA_W       = 64;
  localparam int unsigned OUT_DATA_W      = 416;

  typedef enum logic [1:0] {
    KIND_SEED    = 2'd0,  // very first access: seed slot 0
    KIND_ADVANCE = 2'd1,  // second moved forward: clear passed slots, seed new one
    KIND_ADD     = 2'd2   // same or earlier second: add to current slot
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [STEP_W-1:0]   step;      // seconds advanced, clipped to the ring size
    logic                is_write;
    logic [BYTES_W-1:0]  bytes;
    logic                emit;
    logic [31:0]         now;
  } op_t;

  typedef struct packed {
    logic [31:0] wr_bytes;
    logic [31:0] wr_ops;
    logic [31:0] rd_bytes;
    logic [31:0] rd_ops;
  } bucket_t;

  // First member sits in the highest bits, so total_reads ends up at bit 0.
  typedef struct packed {
    logic [31:0] snapshot_time;
    logic [31:0] write_bytes_prev_second;
    logic [31:0] writes_prev_second;
    logic [31:0] read_bytes_prev_second;
    logic [31:0] reads_prev_second;
    logic [63:0] total_write_bytes;
    logic [63:0] total_writes;
    logic [63:0] total_read_bytes;
    logic [63:0] total_reads;
  } snap_t;

endpackage

// File: src/rmon_front.sv
// rmon_front: takes access requests, tracks the window second and report time,
// and classifies each request into an op for the back end. Depends on rmon_pkg.
module rmon_front #(
  parameter int unsigned RING_SLOTS = rmon_pkg::RING_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [rmon_pkg::GAP_W-1:0]   cfg_data,
  input  logic                         in_valid,
  input  logic                         in_is_write,
  input  logic [rmon_pkg::BYTES_W-1:0] in_bytes,
  input  logic [31:0]                  in_now,
  input  logic                         q_ready,
  output logic                         q_valid,
  output rmon_pkg::op_t                q_data
);
  import rmon_pkg::*;

  logic [31:0]      window_r, window_nxt;
  logic [31:0]      last_report_r, last_report_nxt;
  logic [GAP_W-1:0] gap_r;
  logic             first_evt;
  logic             later;
  logic [31:0]      adv;
  logic             emit;
  logic             take;

  assign take      = in_valid && q_ready;
  assign first_evt = (window_r == '0);
  assign later     = (in_now > window_r);
  assign adv       = in_now - window_r;
  // 33-bit compare so the gap add cannot wrap
  assign emit      = {1'b0, in_now} > ({1'b0, last_report_r} + {{(33-GAP_W){1'b0}}, gap_r});

  always_comb begin
    q_data.is_write = in_is_write;
    q_data.bytes    = in_bytes;
    q_data.emit     = emit;
    q_data.now      = in_now;
    q_data.step     = (adv >= 32'(RING_SLOTS)) ? STEP_W'(RING_SLOTS) : adv[STEP_W-1:0];
    if (first_evt) begin
      q_data.kind = KIND_SEED;
    end else if (later) begin
      q_data.kind = KIND_ADVANCE;
    end else begin
      q_data.kind = KIND_ADD;
    end
  end

  assign q_valid = in_valid;

  always_comb begin
    window_nxt      = window_r;
    last_report_nxt = last_report_r;
    if (take) begin
      if (first_evt || later) begin
        window_nxt = in_now;
      end
      // a snapshot moves the report time up; time going back pulls it down
      if (emit || (in_now < last_report_r)) begin
        last_report_nxt = in_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r      <= '0;
      last_report_r <= '0;
      gap_r         <= REPORT_GAP_RESET;
    end else begin
      window_r      <= window_nxt;
      last_report_r <= last_report_nxt;
      if (cfg_valid) begin
        gap_r <= cfg_data;
      end
    end
  end

endmodule

// File: src/rmon_queue.sv
// rmon_queue: small FIFO of classified ops between front and back end.
// Depends on rmon_pkg for the op type.
module rmon_queue #(
  parameter int unsigned DEPTH = rmon_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  rmon_pkg::op_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output rmon_pkg::op_t rd_data
);
  import rmon_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  op_t              entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = entries_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: src/rmon_back.sv
// rmon_back: applies ops to the 64-bit totals and the ring of per-second
// buckets, and holds the snapshot output register. Depends on rmon_pkg.
module rmon_back #(
  parameter int unsigned RING_SLOTS = rmon_pkg::RING_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  rmon_pkg::op_t   q_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rmon_pkg::snap_t out_data
);
  import rmon_pkg::*;

  localparam int unsigned SLOT_W = $clog2(RING_SLOTS);
  localparam int unsigned SUM_W  = STEP_W + 1;

  logic [63:0]       rd_total_r, rd_total_nxt;
  logic [63:0]       rd_bytes_total_r, rd_bytes_total_nxt;
  logic [63:0]       wr_total_r, wr_total_nxt;
  logic [63:0]       wr_bytes_total_r, wr_bytes_total_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  bucket_t           slot_r   [RING_SLOTS];
  bucket_t           slot_nxt [RING_SLOTS];
  logic              out_valid_r, out_valid_nxt;
  snap_t             out_r;
  logic              pop;
  logic [63:0]       bytes64;
  logic [31:0]       bytes32;
  logic [SUM_W-1:0]  adv_sum;
  logic [SLOT_W-1:0] prev;
  bucket_t           prev_bkt;

  assign q_ready   = !out_valid_r || out_ready;
  assign pop       = q_valid && q_ready;
  assign bytes64   = {{(64-BYTES_W){1'b0}}, q_data.bytes};
  assign bytes32   = {{(32-BYTES_W){1'b0}}, q_data.bytes};
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    rd_total_nxt       = rd_total_r;
    rd_bytes_total_nxt = rd_bytes_total_r;
    wr_total_nxt       = wr_total_r;
    wr_bytes_total_nxt = wr_bytes_total_r;
    if (q_data.is_write) begin
      wr_total_nxt       = wr_total_r + 64'd1;
      wr_bytes_total_nxt = wr_bytes_total_r + bytes64;
    end else begin
      rd_total_nxt       = rd_total_r + 64'd1;
      rd_bytes_total_nxt = rd_bytes_total_r + bytes64;
    end
  end

  // cur + step stays below twice the ring size, so one subtract wraps it.
  // A jump of the whole ring keeps cur; every slot is cleared then, so only
  // positions relative to cur matter.
  assign adv_sum = SUM_W'(cur_r) + SUM_W'(q_data.step);

  always_comb begin
    case (q_data.kind)
      KIND_SEED:    cur_nxt = '0;
      KIND_ADVANCE: cur_nxt = (adv_sum >= SUM_W'(RING_SLOTS)) ?
                              SLOT_W'(adv_sum - SUM_W'(RING_SLOTS)) : SLOT_W'(adv_sum);
      KIND_ADD:     cur_nxt = cur_r;
      default:      cur_nxt = cur_r;
    endcase
  end

  always_comb begin
    logic [SUM_W-1:0] ahead;
    bucket_t          b;
    for (int j = 0; j < RING_SLOTS; j++) begin
      // distance of slot j ahead of cur, 1..RING_SLOTS
      ahead = SUM_W'(j) + SUM_W'(RING_SLOTS) - SUM_W'(cur_r);
      if (ahead >= SUM_W'(RING_SLOTS)) begin
        ahead = ahead - SUM_W'(RING_SLOTS);
      end
      if (ahead == '0) begin
        ahead = SUM_W'(RING_SLOTS);
      end
      b = slot_r[j];
      case (q_data.kind)
        KIND_SEED: begin
          if (j == 0) begin
            if (q_data.is_write) begin
              b.wr_ops   = 32'd1;
              b.wr_bytes = bytes32;
            end else begin
              b.rd_ops   = 32'd1;
              b.rd_bytes = bytes32;
            end
          end
        end
        KIND_ADVANCE: begin
          if (ahead <= SUM_W'(q_data.step)) begin
            b = '0;
          end
          if (SLOT_W'(j) == cur_nxt) begin
            if (q_data.is_write) begin
              b.wr_ops   = 32'd1;
              b.wr_bytes = bytes32;
            end else begin
              b.rd_ops   = 32'd1;
              b.rd_bytes = bytes32;
            end
          end
        end
        KIND_ADD: begin
          if (SLOT_W'(j) == cur_r) begin
            if (q_data.is_write) begin
              b.wr_ops   = b.wr_ops + 32'd1;
              b.wr_bytes = b.wr_bytes + bytes32;
            end else begin
              b.rd_ops   = b.rd_ops + 32'd1;
              b.rd_bytes = b.rd_bytes + bytes32;
            end
          end
        end
        default: b = slot_r[j];
      endcase
      slot_nxt[j] = b;
    end
  end

  assign prev = (cur_nxt == '0) ? SLOT_W'(RING_SLOTS - 1) : cur_nxt - 1'b1;

  always_comb begin
    prev_bkt = '0;
    for (int j = 0; j < RING_SLOTS; j++) begin
      if (SLOT_W'(j) == prev) begin
        prev_bkt = prev_bkt | slot_nxt[j];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && q_data.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_total_r       <= '0;
      rd_bytes_total_r <= '0;
      wr_total_r       <= '0;
      wr_bytes_total_r <= '0;
      cur_r            <= '0;
      out_valid_r      <= 1'b0;
      for (int j = 0; j < RING_SLOTS; j++) begin
        slot_r[j] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        rd_total_r       <= rd_total_nxt;
        rd_bytes_total_r <= rd_bytes_total_nxt;
        wr_total_r       <= wr_total_nxt;
        wr_bytes_total_r <= wr_bytes_total_nxt;
        cur_r            <= cur_nxt;
        for (int j = 0; j < RING_SLOTS; j++) begin
          slot_r[j] <= slot_nxt[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_data.emit) begin
      out_r.total_reads             <= rd_total_nxt;
      out_r.total_read_bytes        <= rd_bytes_total_nxt;
      out_r.total_writes            <= wr_total_nxt;
      out_r.total_write_bytes       <= wr_bytes_total_nxt;
      out_r.reads_prev_second       <= prev_bkt.rd_ops;
      out_r.read_bytes_prev_second  <= prev_bkt.rd_bytes;
      out_r.writes_prev_second      <= prev_bkt.wr_ops;
      out_r.write_bytes_prev_second <= prev_bkt.wr_bytes;
      out_r.snapshot_time           <= q_data.now;
    end
  end

endmodule

// File: src/io_rate_monitor.sv
// io_rate_monitor: top level of the I/O rate monitor.
// Instantiates rmon_front, rmon_queue and rmon_back; depends on rmon_pkg.
//
// Usage:
//   in_*  : one access request per transfer (opcode, byte count, current second).
//   out_* : a snapshot of the 64-bit totals and of the bucket before the
//           current second, sent only when more than report_gap seconds have
//           passed since the last snapshot; most requests produce nothing.
//   cfg_* : writes report_gap (8 bits, 2 after reset); always ready, write
//           only while no request is in flight.
// Throughput: one request per cycle while the queue has room. The front end
// decides the time window and whether a snapshot is due in the accept cycle;
// the back end updates all ring buckets in parallel for each request.
// Snapshot path: the edge that accepts a request writes it into the queue,
// then the back-end update writes its snapshot into the output register,
// which drives out_tvalid; the path is shortest when the queue ahead is empty.
// Reset (rst_n low, synchronous) clears totals, buckets, window and report
// time, empties the queue and drops any pending snapshot.
// Output stall: a held snapshot blocks the back end; the queue (QUEUE_DEPTH
// entries) keeps taking requests until it fills, then in_tready drops.
module io_rate_monitor #(
  parameter int unsigned RING_SLOTS  = rmon_pkg::RING_SLOTS_DEF,
  parameter int unsigned QUEUE_DEPTH = rmon_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] opcode, [31:1] byte_count, [63:32] now_seconds
  input  logic [rmon_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [63:0] total_reads, [127:64] total_read_bytes, [191:128] total_writes,
  // [255:192] total_write_bytes, [287:256] reads_prev_second,
  // [319:288] read_bytes_prev_second, [351:320] writes_prev_second,
  // [383:352] write_bytes_prev_second, [415:384] snapshot_time
  output logic [rmon_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rmon_pkg::GAP_W-1:0]      cfg_data
);
  import rmon_pkg::*;

  op_t   fq_data;
  logic  fq_valid;
  logic  fq_ready;
  op_t   qb_data;
  logic  qb_valid;
  logic  qb_ready;
  snap_t snap;

  assign cfg_ready = 1'b1;
  assign in_tready = fq_ready;
  assign out_tdata = snap;

  rmon_front #(
    .RING_SLOTS (RING_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .in_valid    (in_tvalid),
    .in_is_write (in_tdata[0]),
    .in_bytes    (in_tdata[BYTES_W:1]),
    .in_now      (in_tdata[63:32]),
    .q_ready     (fq_ready),
    .q_valid     (fq_valid),
    .q_data      (fq_data)
  );

  rmon_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  rmon_back #(
    .RING_SLOTS (RING_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (snap)
  );

  // an accepted request is visible to the back end the next cycle
  a_req_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> qb_valid)
    else $error("accepted request did not reach the queue");

  // the back end only stalls behind a held snapshot
  a_back_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (qb_valid && !qb_ready) |-> (out_tvalid && !out_tready))
    else $error("back end stalled without a held snapshot");

  // a new snapshot always comes from an op taken the cycle before
  a_snap_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(qb_valid && qb_ready))
    else $error("snapshot appeared without a back-end update");

endmodule
